FILE: rtl/core/jcs_pkg.sv
// shared types and constants for the joystick calibrate and scale block
`timescale 1ns / 1ps

package jcs_pkg;

    localparam int AXES           = 4;
    localparam int SAMPLE_FIELD_W = 12;
    localparam int SCALE_W        = 15;
    localparam int VALUE_W        = 16;
    localparam int REQ_W          = 2;
    localparam int PHASE_W        = 2;

    localparam logic [REQ_W-1:0] REQ_CONVERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd100;

    typedef enum logic [PHASE_W-1:0] {
        CAL_IDLE  = 2'd0,
        CAL_MID   = 2'd1,
        CAL_RANGE = 2'd2
    } cal_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CALC = 2'd1,
        ST_DONE = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [SAMPLE_FIELD_W-1:0] left_x_sample;
        logic [SAMPLE_FIELD_W-1:0] left_y_sample;
        logic [SAMPLE_FIELD_W-1:0] right_x_sample;
        logic [SAMPLE_FIELD_W-1:0] right_y_sample;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] left_x_value;
        logic signed [VALUE_W-1:0] left_y_value;
        logic signed [VALUE_W-1:0] right_x_value;
        logic signed [VALUE_W-1:0] right_y_value;
        logic [AXES-1:0]           span_ok_mask;
        logic [PHASE_W-1:0]        cal_phase;
    } rsp_t;

    typedef struct packed {
        logic done;
        logic span_ok;
    } lane_stat_t;

endpackage

FILE: rtl/core/jcs_lane.sv
// one axis lane: span select, scale multiply or group average, and serial restoring divider
`timescale 1ns / 1ps

module jcs_lane #(
    parameter int SAMPLE_BITS = 12,
    parameter int AVG_SAMPLES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  avg_mode,
    input  logic [SAMPLE_BITS-1:0]                sample,
    input  logic [SAMPLE_BITS-1:0]                center,
    input  logic [SAMPLE_BITS:0]                  upper_lim,
    input  logic [SAMPLE_BITS:0]                  lower_lim,
    input  logic [SAMPLE_BITS+$clog2(AVG_SAMPLES)-1:0] sum,
    input  logic [jcs_pkg::SCALE_W-1:0]           scale,
    output jcs_pkg::lane_stat_t                   stat,
    output logic signed [jcs_pkg::VALUE_W-1:0]    value,
    output logic [SAMPLE_BITS-1:0]                avg
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES);
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int NW    = SAMPLE_BITS + jcs_pkg::SCALE_W;
    localparam int CW    = $clog2(NW + 1);
    localparam int SPW   = SAMPLE_BITS + 2;

    // group average by reciprocal multiply: ceil(2^RSH / AVG_SAMPLES) is exact
    // for every sum that fits SUM_W bits
    localparam int RL   = $clog2(AVG_SAMPLES);
    localparam int RSH  = SUM_W + RL;
    localparam int RMW  = SUM_W + 1;
    localparam int PW   = SUM_W + RMW;
    localparam logic [RMW-1:0] RMUL =
        RMW'(((64'd1 << RSH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    logic                   avg_mode_reg;
    logic                   upper_side_reg;
    logic                   ok_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [DW-1:0]          div_reg;
    logic [DW-1:0]          rem_reg;
    logic [NW-1:0]          quo_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   load_reg;
    logic                   done_reg;

    logic                   upper_side;
    logic signed [SPW-1:0]  span;
    logic [SAMPLE_BITS-1:0] mag;
    logic [DW:0]            rem_sh;
    logic                   fits;
    logic [jcs_pkg::SCALE_W-1:0] mag_clamped;
    logic [PW-1:0]          avg_prod;

    // span and distance from the center, taken at start
    always_comb
    begin
        upper_side = (sample > center);
        if (upper_side)
        begin
            span = SPW'($signed({1'b0, upper_lim})) - SPW'($signed({2'b00, center}));
            mag  = sample - center;
        end
        else
        begin
            span = SPW'($signed({2'b00, center})) - SPW'($signed({1'b0, lower_lim}));
            mag  = center - sample;
        end
    end

    assign rem_sh   = {rem_reg, quo_reg[NW-1]};
    assign fits     = (rem_sh >= {1'b0, div_reg});
    assign avg_prod = PW'(sum_reg) * PW'(RMUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            load_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
            // averages are ready at load, scaling runs the divider
            if (avg_mode_reg)
            begin
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= CW'(NW);
            end
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            avg_mode_reg   <= avg_mode;
            upper_side_reg <= upper_side;
            ok_reg         <= (span > 0);
            mag_reg        <= mag;
            sum_reg        <= sum;
            div_reg        <= span[DW-1:0];
        end
        else if (load_reg)
        begin
            rem_reg <= '0;
            if (avg_mode_reg)
            begin
                quo_reg <= NW'(avg_prod[PW-1:RSH]);
            end
            else
            begin
                quo_reg <= NW'(mag_reg) * NW'(scale);
            end
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= DW'(rem_sh - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
            end
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    // clamp to full deflection, then sign by side of the center; zero without a positive span
    always_comb
    begin
        if (quo_reg > NW'(scale))
        begin
            mag_clamped = scale;
        end
        else
        begin
            mag_clamped = quo_reg[jcs_pkg::SCALE_W-1:0];
        end
        if (!ok_reg)
        begin
            value = '0;
        end
        else if (upper_side_reg)
        begin
            value = $signed(jcs_pkg::VALUE_W'(mag_clamped));
        end
        else
        begin
            value = $signed(jcs_pkg::VALUE_W'(0) - jcs_pkg::VALUE_W'(mag_clamped));
        end
    end

    assign avg          = quo_reg[SAMPLE_BITS-1:0];
    assign stat.done    = done_reg;
    assign stat.span_ok = ok_reg;

endmodule

FILE: rtl/core/jcs_merge.sv
// merge stage: builds the result and the new calibration centers and limits from the lanes
`timescale 1ns / 1ps

module jcs_merge #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               is_convert,
    input  logic                               phase_mid,
    input  logic [jcs_pkg::PHASE_W-1:0]        phase,
    input  jcs_pkg::lane_stat_t                lane_stat [jcs_pkg::AXES],
    input  logic signed [jcs_pkg::VALUE_W-1:0] lane_value [jcs_pkg::AXES],
    input  logic [SAMPLE_BITS-1:0]             lane_avg [jcs_pkg::AXES],
    input  logic [SAMPLE_BITS-1:0]             center [jcs_pkg::AXES],
    input  logic [SAMPLE_BITS:0]               upper_lim [jcs_pkg::AXES],
    input  logic [SAMPLE_BITS:0]               lower_lim [jcs_pkg::AXES],
    output jcs_pkg::rsp_t                      rsp,
    output logic [SAMPLE_BITS-1:0]             center_new [jcs_pkg::AXES],
    output logic [SAMPLE_BITS:0]               upper_new [jcs_pkg::AXES],
    output logic [SAMPLE_BITS:0]               lower_new [jcs_pkg::AXES]
);

    logic signed [jcs_pkg::VALUE_W-1:0] val [jcs_pkg::AXES];
    logic [jcs_pkg::AXES-1:0]           mask;

    always_comb
    begin
        for (int a = 0; a < jcs_pkg::AXES; a++)
        begin
            if (is_convert)
            begin
                val[a]  = lane_value[a];
                mask[a] = lane_stat[a].span_ok;
            end
            else
            begin
                val[a]  = '0;
                mask[a] = 1'b0;
            end
        end
    end

    // midpoint group sets the centers, range groups only widen the limits
    always_comb
    begin
        for (int a = 0; a < jcs_pkg::AXES; a++)
        begin
            center_new[a] = center[a];
            upper_new[a]  = upper_lim[a];
            lower_new[a]  = lower_lim[a];
            if (phase_mid)
            begin
                center_new[a] = lane_avg[a];
            end
            else
            begin
                if ({1'b0, lane_avg[a]} > upper_lim[a])
                begin
                    upper_new[a] = {1'b0, lane_avg[a]};
                end
                if ({1'b0, lane_avg[a]} < lower_lim[a])
                begin
                    lower_new[a] = {1'b0, lane_avg[a]};
                end
            end
        end
    end

    assign rsp.left_x_value  = val[0];
    assign rsp.left_y_value  = val[1];
    assign rsp.right_x_value = val[2];
    assign rsp.right_y_value = val[3];
    assign rsp.span_ok_mask  = mask;
    assign rsp.cal_phase     = phase;

endmodule

FILE: rtl/core/joystick_calibrate_scale_top.sv
// top level of the joystick center/range calibration and scaling block
`timescale 1ns / 1ps

//  channel   signals                          direction  transaction
//  req       req_valid, req_stall, req_data   in         valid && !stall
//  rsp       rsp_valid, rsp_stall, rsp_data   out        valid && !stall
//  cfg       cfg_valid, cfg_ready, cfg_data   in         valid && ready
//
//  one request at a time; a convert starts the four lanes, which load the scaled
//  magnitude and then divide, one quotient bit per cycle over SAMPLE_BITS + 15
//  bits, before the merged result goes to the output register; a group-closing
//  calibration sample averages by reciprocal multiply in the lanes; other
//  requests skip the lanes; the next request is taken while a finished result
//  waits in the output register; reset restores centers, limits, the scale
//  register and phase

module joystick_calibrate_scale_top #(
    parameter int AVG_SAMPLES = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  jcs_pkg::req_t                req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output jcs_pkg::rsp_t                rsp_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [jcs_pkg::SCALE_W-1:0]  cfg_data
);

    localparam int AXES  = jcs_pkg::AXES;
    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES);
    localparam int CNT_W = $clog2(AVG_SAMPLES + 1);

    // control state
    jcs_pkg::ctl_state_t state_reg, state_next;
    jcs_pkg::cal_phase_t phase_reg;
    logic                rsp_valid_reg;
    logic [CNT_W-1:0]    count_reg;

    // calibration and configuration state
    logic [jcs_pkg::SCALE_W-1:0] scale_reg;
    logic [SAMPLE_BITS-1:0]      center_reg [AXES];
    logic [SAMPLE_BITS:0]        upper_reg  [AXES];
    logic [SAMPLE_BITS:0]        lower_reg  [AXES];
    logic [SUM_W-1:0]            sum_reg    [AXES];

    // item flags kept while the lanes run
    logic          conv_reg;
    logic          avg_reg;
    jcs_pkg::rsp_t rsp_data_reg;

    logic                   req_accept;
    logic                   is_conv;
    logic                   is_start;
    logic                   is_cal;
    logic                   group_done;
    logic [CNT_W-1:0]       count_inc;
    logic                   lane_start;
    logic                   rsp_load;
    logic                   all_done;
    logic [AXES-1:0]        done_vec;
    logic [SAMPLE_BITS-1:0] samp [AXES];
    logic [SUM_W-1:0]       sum_inc [AXES];

    jcs_pkg::lane_stat_t                lane_stat  [AXES];
    logic signed [jcs_pkg::VALUE_W-1:0] lane_value [AXES];
    logic [SAMPLE_BITS-1:0]             lane_avg   [AXES];

    jcs_pkg::rsp_t          merge_rsp;
    logic [SAMPLE_BITS-1:0] center_new [AXES];
    logic [SAMPLE_BITS:0]   upper_new  [AXES];
    logic [SAMPLE_BITS:0]   lower_new  [AXES];

    // samples use the low SAMPLE_BITS of each field
    assign samp[0] = SAMPLE_BITS'(req_data.left_x_sample);
    assign samp[1] = SAMPLE_BITS'(req_data.left_y_sample);
    assign samp[2] = SAMPLE_BITS'(req_data.right_x_sample);
    assign samp[3] = SAMPLE_BITS'(req_data.right_y_sample);

    assign req_stall  = (state_reg != jcs_pkg::ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    assign is_conv    = (req_data.req_type == jcs_pkg::REQ_CONVERT);
    assign is_start   = (req_data.req_type == jcs_pkg::REQ_START);
    assign is_cal     = (req_data.req_type == jcs_pkg::REQ_SAMPLE)
                        && (phase_reg != jcs_pkg::CAL_IDLE);
    assign count_inc  = count_reg + 1'b1;
    assign group_done = is_cal && (count_inc == CNT_W'(AVG_SAMPLES));

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sum_inc[a]  = sum_reg[a] + SUM_W'(samp[a]);
            done_vec[a] = lane_stat[a].done;
        end
    end
    assign all_done = &done_vec;

    // lanes, one per axis
    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        jcs_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AVG_SAMPLES (AVG_SAMPLES)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (lane_start),
            .avg_mode  (!is_conv),
            .sample    (samp[g]),
            .center    (center_reg[g]),
            .upper_lim (upper_reg[g]),
            .lower_lim (lower_reg[g]),
            .sum       (sum_inc[g]),
            .scale     (scale_reg),
            .stat      (lane_stat[g]),
            .value     (lane_value[g]),
            .avg       (lane_avg[g])
        );
    end

    jcs_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .is_convert (conv_reg),
        .phase_mid  (phase_reg == jcs_pkg::CAL_MID),
        .phase      (phase_reg),
        .lane_stat  (lane_stat),
        .lane_value (lane_value),
        .lane_avg   (lane_avg),
        .center     (center_reg),
        .upper_lim  (upper_reg),
        .lower_lim  (lower_reg),
        .rsp        (merge_rsp),
        .center_new (center_new),
        .upper_new  (upper_new),
        .lower_new  (lower_new)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lane_start = 1'b0;
        rsp_load   = 1'b0;
        case (state_reg)
            jcs_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (is_conv || group_done)
                    begin
                        lane_start = 1'b1;
                        state_next = jcs_pkg::ST_CALC;
                    end
                    else
                    begin
                        state_next = jcs_pkg::ST_DONE;
                    end
                end
            end
            jcs_pkg::ST_CALC:
            begin
                if (all_done)
                begin
                    state_next = jcs_pkg::ST_DONE;
                end
            end
            jcs_pkg::ST_DONE:
            begin
                // output register free or draining this cycle
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = jcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jcs_pkg::ST_IDLE;
            end
        endcase
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jcs_pkg::CAL_IDLE;
            count_reg <= '0;
            scale_reg <= jcs_pkg::SCALE_RESET;
            for (int a = 0; a < AXES; a++)
            begin
                center_reg[a] <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
                upper_reg[a]  <= {1'b0, {SAMPLE_BITS{1'b1}}};
                lower_reg[a]  <= '0;
                sum_reg[a]    <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
            if (req_accept && is_start)
            begin
                phase_reg <= jcs_pkg::CAL_MID;
                count_reg <= '0;
                for (int a = 0; a < AXES; a++)
                begin
                    upper_reg[a] <= '0;
                    lower_reg[a] <= {1'b1, {SAMPLE_BITS{1'b0}}};
                    sum_reg[a]   <= '0;
                end
            end
            else if (req_accept && is_cal)
            begin
                // a closing group hands its sums to the lanes and restarts
                if (group_done)
                begin
                    count_reg <= '0;
                    for (int a = 0; a < AXES; a++)
                    begin
                        sum_reg[a] <= '0;
                    end
                end
                else
                begin
                    count_reg <= count_inc;
                    for (int a = 0; a < AXES; a++)
                    begin
                        sum_reg[a] <= sum_inc[a];
                    end
                end
            end
            else if ((state_reg == jcs_pkg::ST_CALC) && all_done && avg_reg)
            begin
                phase_reg <= jcs_pkg::CAL_RANGE;
                for (int a = 0; a < AXES; a++)
                begin
                    center_reg[a] <= center_new[a];
                    upper_reg[a]  <= upper_new[a];
                    lower_reg[a]  <= lower_new[a];
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            conv_reg <= is_conv;
            avg_reg  <= group_done;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= merge_rsp;
        end
    end

    // checks
    a_phase_no_return: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != jcs_pkg::CAL_IDLE) |=> (phase_reg != jcs_pkg::CAL_IDLE))
        else $error("calibration phase fell back to idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < CNT_W'(AVG_SAMPLES)))
        else $error("sample count reached the group size");

    a_lane_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(done_vec) == 0) || ($countones(done_vec) == AXES))
        else $error("lanes out of step");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == jcs_pkg::ST_DONE))
        else $error("result raised outside the done state");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the joystick calibrate and scale block
`timescale 1ns / 1ps

module tb_top;
    import jcs_pkg::*;

    // samples per average, as the block is built with its default parameters
    localparam int AVG_N = 16;
    localparam int SAMPLE_MAX = 4095;
    // one past full scale, where a fresh calibration parks the lower limits
    localparam int FULL_SCALE = 4096;
    // settling margin waited after the last response, longer than the block's longest request
    localparam int SETTLE_CYCLES = 40;
    // cycles with no transaction on any channel before the run is declared hung
    localparam int STUCK_LIMIT = 3000;
    // length of the long receiver hold-off that backs up the block
    localparam int LONG_HOLD = 400;
    localparam int REPORT_LIMIT = 10;

    // request code that the block does not use; must be ignored
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_data = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SCALE_W-1:0]   cfg_data = SCALE_RESET;

    // stimulus waiting for the driver, and responses waiting for the block
    req_t queued_reqs [$];
    rsp_t predicted_rsps [$];

    // shadow copy of the calibration state and the scale register
    logic [SCALE_W-1:0]    scale_reg;
    logic [11:0]           center_pt [AXES];
    logic [12:0]           upper_lim [AXES];
    logic [12:0]           lower_lim [AXES];
    logic [15:0]           group_sum [AXES];
    int unsigned           group_cnt;
    cal_phase_t            cal_state;

    // stimulus bookkeeping
    int aim_center [AXES];
    int queued_in_phase;
    int failures = 0;
    int stuck_cycles = 0;
    bit req_gapless = 1'b0;
    bit rsp_gapless = 1'b0;
    int holds_asked = 0;
    int holds_granted = 0;
    int req_gap_left = 0;
    int rsp_hold_left = 0;

    joystick_calibrate_scale_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // piecewise-linear mapping of one axis about its center; ok flags a positive span
    function automatic logic [VALUE_W-1:0] scaled_deflection(int sample, int axis,
                                                             output logic ok);
        int     ctr;
        int     span;
        longint mag;
        longint res;
        logic   above;
        ctr = center_pt[axis];
        res = scale_reg;
        above = sample > ctr;
        // sample on the center goes down the lower branch
        span = above ? int'(upper_lim[axis]) - ctr : ctr - int'(lower_lim[axis]);
        ok = 1'b0;
        if (span <= 0)
            return '0;
        ok = 1'b1;
        mag = above ? longint'(sample - ctr) : longint'(ctr - sample);
        mag = (mag * res) / span;
        if (mag > res)
            mag = res;
        return above ? VALUE_W'(mag) : VALUE_W'(-mag);
    endfunction

    // response to one request; advances the shadow calibration state
    function automatic rsp_t calibrate_and_scale(req_t it);
        rsp_t            r;
        logic [11:0]     s [AXES];
        logic [15:0]     v [AXES];
        logic [AXES-1:0] ok;
        logic            lane_ok;
        logic [11:0]     avg;
        s[0] = it.left_x_sample;
        s[1] = it.left_y_sample;
        s[2] = it.right_x_sample;
        s[3] = it.right_y_sample;
        ok = '0;
        for (int a = 0; a < AXES; a++)
            v[a] = '0;
        case (it.req_type)
            REQ_CONVERT:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    v[a] = scaled_deflection(int'(s[a]), a, lane_ok);
                    ok[a] = lane_ok;
                end
            end
            REQ_START:
            begin
                // limits collapse so the range groups can widen them; centers stay
                for (int a = 0; a < AXES; a++)
                begin
                    upper_lim[a] = '0;
                    lower_lim[a] = 13'(FULL_SCALE);
                    group_sum[a] = '0;
                end
                group_cnt = 0;
                cal_state = CAL_MID;
            end
            REQ_SAMPLE:
            begin
                // ignored while idle
                if (cal_state != CAL_IDLE)
                begin
                    for (int a = 0; a < AXES; a++)
                        group_sum[a] = group_sum[a] + 16'(s[a]);
                    group_cnt++;
                    if (group_cnt >= AVG_N)
                    begin
                        for (int a = 0; a < AXES; a++)
                        begin
                            avg = 12'(group_sum[a] / AVG_N);
                            if (cal_state == CAL_MID)
                                center_pt[a] = avg;
                            else
                            begin
                                if (13'(avg) > upper_lim[a])
                                    upper_lim[a] = 13'(avg);
                                if (13'(avg) < lower_lim[a])
                                    lower_lim[a] = 13'(avg);
                            end
                            group_sum[a] = '0;
                        end
                        group_cnt = 0;
                        cal_state = CAL_RANGE;
                    end
                end
            end
            default: ;
        endcase
        r.left_x_value  = v[0];
        r.left_y_value  = v[1];
        r.right_x_value = v[2];
        r.right_y_value = v[3];
        r.span_ok_mask  = ok;
        r.cal_phase     = cal_state;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic log_failure(string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            log_failure($sformatf("%s expected %0d got %0d", name,
                                  $signed(want), $signed(got)));
    endtask

    // config shadowing, response compare and request prediction share one process
    // so the shadow state is updated in transaction order
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                scale_reg = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsps.size() == 0)
                    log_failure("response transaction with nothing outstanding");
                else
                begin
                    want = predicted_rsps.pop_front();
                    check_field("left_x_value", rsp_data.left_x_value, want.left_x_value);
                    check_field("left_y_value", rsp_data.left_y_value, want.left_y_value);
                    check_field("right_x_value", rsp_data.right_x_value, want.right_x_value);
                    check_field("right_y_value", rsp_data.right_y_value, want.right_y_value);
                    check_field("span_ok_mask", 16'(rsp_data.span_ok_mask),
                                16'(want.span_ok_mask));
                    check_field("cal_phase", 16'(rsp_data.cal_phase), 16'(want.cal_phase));
                end
            end
            if (req_valid && !req_stall)
                predicted_rsps.push_back(calibrate_and_scale(req_data));
        end
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request driver and response stall generator
    // ------------------------------------------------------------------

    // mostly back to back, often a short gap, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            req_gap_left = 0;
        end
        else
        begin
            // payload holds while stalled; a new one goes out only once the slot frees
            next_valid = req_valid;
            if (req_valid && !req_stall)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (req_gap_left > 0)
                    req_gap_left--;
                else if (queued_reqs.size() > 0)
                begin
                    req_data <= queued_reqs.pop_front();
                    next_valid = 1'b1;
                    req_gap_left = req_gapless ? 0 : idle_gap();
                end
            end
            req_valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold_left = 0;
        end
        else
        begin
            // a long hold-off asked by the sequencer overrides the random stalls
            if (holds_granted != holds_asked)
            begin
                holds_granted++;
                rsp_hold_left = LONG_HOLD;
            end
            if (rsp_hold_left > 0)
            begin
                rsp_hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                rsp_hold_left = rsp_gapless ? 0 : idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic offer(logic [REQ_W-1:0] kind, logic [11:0] lx, logic [11:0] ly,
                         logic [11:0] rx, logic [11:0] ry);
        req_t it;
        it.req_type = kind;
        it.left_x_sample = lx;
        it.left_y_sample = ly;
        it.right_x_sample = rx;
        it.right_y_sample = ry;
        queued_reqs.push_back(it);
        queued_in_phase++;
    endtask

    function automatic logic [11:0] clip_sample(int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return 12'(SAMPLE_MAX);
        return 12'(v);
    endfunction

    function automatic logic [11:0] rand_sample();
        return 12'($urandom_range(0, SAMPLE_MAX));
    endfunction

    // converter reading biased toward the rails and the calibrated center
    function automatic logic [11:0] pick_sample(int aim);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 12'(SAMPLE_MAX);
            2: return clip_sample(aim);
            3: return clip_sample(aim + $urandom_range(0, 4) - 2);
            default: return rand_sample();
        endcase
    endfunction

    task automatic offer_convert();
        offer(REQ_CONVERT, pick_sample(aim_center[0]), pick_sample(aim_center[1]),
              pick_sample(aim_center[2]), pick_sample(aim_center[3]));
    endtask

    task automatic maybe_convert();
        if ($urandom_range(0, 3) == 0)
            offer_convert();
    endtask

    // full calibration: start, a midpoint group, then range groups, converts mixed in
    task automatic run_calibration(int groups);
        int          d [AXES];
        logic [11:0] lvl [AXES];
        offer(REQ_START, rand_sample(), rand_sample(), rand_sample(), rand_sample());
        maybe_convert();
        for (int a = 0; a < AXES; a++)
            aim_center[a] = $urandom_range(300, SAMPLE_MAX - 300);
        // paired +/- offsets keep the midpoint average exactly on aim
        for (int i = 0; i < AVG_N; i += 2)
        begin
            for (int a = 0; a < AXES; a++)
                d[a] = $urandom_range(0, 250);
            offer(REQ_SAMPLE, 12'(aim_center[0] + d[0]), 12'(aim_center[1] + d[1]),
                  12'(aim_center[2] + d[2]), 12'(aim_center[3] + d[3]));
            maybe_convert();
            offer(REQ_SAMPLE, 12'(aim_center[0] - d[0]), 12'(aim_center[1] - d[1]),
                  12'(aim_center[2] - d[2]), 12'(aim_center[3] - d[3]));
            maybe_convert();
        end
        // each range group settles at its own level per axis
        for (int g = 0; g < groups; g++)
        begin
            for (int a = 0; a < AXES; a++)
                lvl[a] = rand_sample();
            for (int i = 0; i < AVG_N; i++)
            begin
                offer(REQ_SAMPLE,
                      clip_sample(int'(lvl[0]) + $urandom_range(0, 64) - 32),
                      clip_sample(int'(lvl[1]) + $urandom_range(0, 64) - 32),
                      clip_sample(int'(lvl[2]) + $urandom_range(0, 64) - 32),
                      clip_sample(int'(lvl[3]) + $urandom_range(0, 64) - 32));
                maybe_convert();
            end
        end
        repeat ($urandom_range(3, 12))
            offer_convert();
    endtask

    // mostly calibration sessions, plus convert bursts, aborted sessions and noise
    task automatic random_traffic(int target);
        queued_in_phase = 0;
        while (queued_in_phase < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: run_calibration($urandom_range(1, 3));
                5, 6, 7:
                    repeat ($urandom_range(4, 20))
                        offer_convert();
                8:
                begin
                    // session cut short by a fresh start
                    offer(REQ_START, rand_sample(), rand_sample(), rand_sample(),
                          rand_sample());
                    repeat ($urandom_range(1, AVG_N - 1))
                        offer(REQ_SAMPLE, rand_sample(), rand_sample(), rand_sample(),
                              rand_sample());
                end
                default:
                    repeat ($urandom_range(1, 6))
                        offer(REQ_W'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                              rand_sample(), rand_sample());
            endcase
        end
    endtask

    // block is idle once everything sent has come back and the latency has passed
    task automatic wait_quiet();
        while (queued_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        // shadow state as after reset
        scale_reg = SCALE_RESET;
        for (int a = 0; a < AXES; a++)
        begin
            center_pt[a] = 12'(FULL_SCALE / 2);
            upper_lim[a] = 13'(SAMPLE_MAX);
            lower_lim[a] = '0;
            group_sum[a] = '0;
            aim_center[a] = FULL_SCALE / 2;
        end
        group_cnt = 0;
        cal_state = CAL_IDLE;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: rails, center and its neighbors, bit patterns at reset calibration
        offer(REQ_CONVERT, 12'd0, 12'd0, 12'd0, 12'd0);
        offer(REQ_CONVERT, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        offer(REQ_CONVERT, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
        offer(REQ_CONVERT, 12'd2049, 12'd2047, 12'd4094, 12'd1);
        offer(REQ_CONVERT, 12'hAAA, 12'h555, 12'hFFF, 12'h000);
        // calibration sample while idle and the unused code are both ignored
        offer(REQ_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        offer(REQ_UNUSED, 12'hFFF, 12'h000, 12'h555, 12'hAAA);
        offer(REQ_START, 12'h555, 12'hAAA, 12'h000, 12'hFFF);
        // limits are collapsed during the midpoint phase: no positive span anywhere
        offer(REQ_CONVERT, 12'd0, 12'hFFF, 12'd2048, 12'd100);
        for (int i = 0; i < AVG_N; i++)
            offer(REQ_SAMPLE, 12'(1000 + i), 12'(3000 - i), 12'hFFF, 12'h000);
        // centers set, range not yet widened: spans still not positive
        offer(REQ_CONVERT, 12'hFFF, 12'd0, 12'd1, 12'd4094);
        wait_quiet();

        // reset scale, random idling on both sides
        random_traffic(450);
        wait_quiet();

        // full-scale resolution, no idling at all
        write_scale(15'h7FFF);
        req_gapless = 1'b1;
        rsp_gapless = 1'b1;
        random_traffic(400);
        wait_quiet();
        req_gapless = 1'b0;
        rsp_gapless = 1'b0;

        // smallest resolution
        write_scale(15'd1);
        random_traffic(250);
        wait_quiet();

        // zero resolution: every value collapses to zero
        write_scale('0);
        random_traffic(80);
        wait_quiet();

        // random resolution with a long receiver hold-off while requests keep coming
        write_scale(SCALE_W'($urandom_range(2, 32766)));
        random_traffic(450);
        holds_asked++;
        wait_quiet();

        if (predicted_rsps.size() != 0)
            log_failure($sformatf("%0d responses never arrived", predicted_rsps.size()));
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/jcs_pkg.sv
rtl/core/jcs_lane.sv
rtl/core/jcs_merge.sv
rtl/core/joystick_calibrate_scale_top.sv
tb/tb_top.sv
